[design/bads_pkg.sv]
// ----------------------------------------------------------------------------
// bads_pkg: shared definitions for the block average downscaler
// Field widths, configuration register indexes, reset values and the flag
// group that travels with each icon pixel through the divider.
// ----------------------------------------------------------------------------
package bads_pkg;

  // Default geometry: icon side in pixels and the largest tile side.
  localparam int ICON_SIDE_DEF = 64;
  localparam int TILE_MAX_DEF  = 64;

  // Fixed field widths.
  localparam int GRAY_W    = 16;  // grey level and average
  localparam int PIX_W     = 17;  // signed input sample
  localparam int BLK_W     = 7;   // block_size register
  localparam int CFG_W     = 16;  // configuration write data
  localparam int CFG_IDX_W = 1;   // configuration register index

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GRAY   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 1'd1;

  // Reset value of max_gray.
  localparam logic [GRAY_W-1:0] MAX_GRAY_RST = 16'd255;

  // Position flags of one icon pixel.
  typedef struct packed {
    logic row_end;
    logic image_end;
  } tile_flags_t;

endpackage

[design/bads_divider.sv]
// ----------------------------------------------------------------------------
// bads_divider: pipelined restoring divider
// Divides a tile sum by the tile area, one quotient bit per stage, and carries
// the tile column and position flags alongside. All stages move on en.
// ----------------------------------------------------------------------------
module bads_divider
  import bads_pkg::*;
#(
  parameter int SUM_W = 28,
  parameter int DIV_W = 14,
  parameter int Q_W   = 16,
  parameter int TC_W  = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [SUM_W-1:0] in_sum,
  input  logic [DIV_W-1:0] divisor,
  input  logic [TC_W-1:0]  in_tc,
  input  tile_flags_t      in_flags,
  output logic             out_valid,
  output logic [Q_W-1:0]   out_quot,
  output logic [TC_W-1:0]  out_tc,
  output tile_flags_t      out_flags
);

  localparam int CMP_W = (SUM_W > DIV_W + Q_W) ? SUM_W : DIV_W + Q_W;

  logic [Q_W:0]     v_r;
  logic [SUM_W-1:0] rem_r   [Q_W+1];
  logic [Q_W-1:0]   q_r     [Q_W+1];
  logic [TC_W-1:0]  tc_r    [Q_W+1];
  tile_flags_t      flg_r   [Q_W+1];
  logic [SUM_W-1:0] rem_nxt [Q_W];
  logic [Q_W-1:0]   q_nxt   [Q_W];
  logic [CMP_W-1:0] shifted [Q_W];

  // Stage k decides quotient bit Q_W-1-k.
  always_comb begin
    for (int k = 0; k < Q_W; k++) begin
      shifted[k] = CMP_W'(divisor) << (Q_W - 1 - k);
      if (CMP_W'(rem_r[k]) >= shifted[k]) begin
        rem_nxt[k] = SUM_W'(CMP_W'(rem_r[k]) - shifted[k]);
        q_nxt[k]   = q_r[k] | (Q_W'(1) << (Q_W - 1 - k));
      end else begin
        rem_nxt[k] = rem_r[k];
        q_nxt[k]   = q_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[Q_W-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= in_sum;
      q_r[0]   <= '0;
      tc_r[0]  <= in_tc;
      flg_r[0] <= in_flags;
      for (int k = 0; k < Q_W; k++) begin
        rem_r[k+1] <= rem_nxt[k];
        q_r[k+1]   <= q_nxt[k];
        tc_r[k+1]  <= tc_r[k];
        flg_r[k+1] <= flg_r[k];
      end
    end
  end

  assign out_valid = v_r[Q_W];
  assign out_quot  = q_r[Q_W];
  assign out_tc    = tc_r[Q_W];
  assign out_flags = flg_r[Q_W];

endmodule

[design/block_average_downscale_unit.sv]
// ----------------------------------------------------------------------------
// block_average_downscale_unit: box-filter downscaler to a square icon
// Streams grey samples in raster order and emits the floor average of every
// block_size by block_size tile as one icon pixel.
// ----------------------------------------------------------------------------
// The unit takes one pixel transfer per clock cycle, sustained, for as long as
// the result side keeps up; the tile-sum memory, with one read and one write
// port, does one read-modify-write per pixel, and a forwarding register covers
// back-to-back pixels in the same tile column. An icon pixel appears on the
// output once its tile's bottom-right sample has passed the register stages,
// and can transfer at the next edge at the earliest. Q_W + 2 register stages
// lie between input and output: the accumulate stage, which is loaded at the
// transfer edge together with the memory read data, the divider's load stage,
// and one divider stage per quotient bit. A stalled result freezes the whole
// pipeline, so the input side stalls in the same cycle.
// Writing block_size restarts the image at once: sums are dropped through a
// valid bit per column entry, so no clearing pass is needed after reset or
// after the write. Samples below zero or above max_gray add zero to the sum.
// Configuration must only be written while no pixel is in flight.
// ----------------------------------------------------------------------------
module block_average_downscale_unit
  import bads_pkg::*;
#(
  parameter int ICON_SIDE = ICON_SIDE_DEF,
  parameter int TILE_MAX  = TILE_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Configuration write port
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_wdata,
  // Pixel input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [PIX_W-1:0]      in_pixel_value,
  // Icon pixel output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [GRAY_W-1:0]            out_average,
  output logic [$clog2(ICON_SIDE)-1:0] out_tile_column,
  output logic                         out_row_end,
  output logic                         out_image_end
);

  // Derived widths.
  localparam int TC_W   = $clog2(ICON_SIDE);
  localparam int CIT_W  = (TILE_MAX > 1) ? $clog2(TILE_MAX) : 1;
  localparam int EB_W   = $clog2(TILE_MAX + 1);
  localparam int EXT_W  = (EB_W > BLK_W) ? EB_W : BLK_W;
  localparam int DIV_W  = 2 * EB_W;
  localparam int SUM_W  = GRAY_W + 2 * $clog2(TILE_MAX);
  localparam int Q_W    = GRAY_W;

  // --------------------------------------------------------------------------
  // Configuration registers. The tile side is stored already clamped, as
  // side minus one for the position counters and as the tile area for the
  // divider.
  // --------------------------------------------------------------------------
  logic [GRAY_W-1:0] max_gray_r;
  logic [CIT_W-1:0]  bs_m1_r;
  logic [DIV_W-1:0]  bs_sq_r;
  logic [EXT_W-1:0]  blk_ext;
  logic [EB_W-1:0]   blk_eff;
  logic              restart;

  assign restart = cfg_we && (cfg_index == REG_BLOCK_SIZE);
  assign blk_ext = EXT_W'(cfg_wdata[BLK_W-1:0]);

  // A zero tile side acts as one, and anything above TILE_MAX as TILE_MAX.
  always_comb begin
    if (blk_ext == '0) begin
      blk_eff = EB_W'(1);
    end else if (blk_ext > EXT_W'(TILE_MAX)) begin
      blk_eff = EB_W'(TILE_MAX);
    end else begin
      blk_eff = EB_W'(blk_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_gray_r <= MAX_GRAY_RST;
      bs_m1_r    <= '0;
      bs_sq_r    <= DIV_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_GRAY: begin
          max_gray_r <= cfg_wdata[GRAY_W-1:0];
        end
        REG_BLOCK_SIZE: begin
          bs_m1_r <= CIT_W'(blk_eff - EB_W'(1));
          bs_sq_r <= DIV_W'(blk_eff) * DIV_W'(blk_eff);
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline enable: everything advances unless a finished icon pixel is
  // waiting on a stalled output.
  // --------------------------------------------------------------------------
  logic en;
  logic in_xfer;
  logic div_out_valid;

  assign en       = !div_out_valid || !out_stall;
  assign in_stall = !en;
  assign in_xfer  = in_valid && en;

  // --------------------------------------------------------------------------
  // Position counters: sample column inside the tile, tile column, sample row
  // inside the tile row, and tile row.
  // --------------------------------------------------------------------------
  logic [CIT_W-1:0] col_in_tile_r;
  logic [TC_W-1:0]  tile_col_r;
  logic [CIT_W-1:0] row_in_tile_r;
  logic [TC_W-1:0]  tile_row_r;
  logic             col_last;
  logic             tcol_last;
  logic             rit_last;
  logic             trow_last;
  logic             line_end;

  assign col_last  = (col_in_tile_r == bs_m1_r);
  assign tcol_last = (tile_col_r == TC_W'(ICON_SIDE - 1));
  assign rit_last  = (row_in_tile_r == bs_m1_r);
  assign trow_last = (tile_row_r == TC_W'(ICON_SIDE - 1));
  assign line_end  = col_last && tcol_last;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_in_tile_r <= '0;
      tile_col_r    <= '0;
      row_in_tile_r <= '0;
      tile_row_r    <= '0;
    end else if (in_xfer) begin
      col_in_tile_r <= col_last ? '0 : col_in_tile_r + CIT_W'(1);
      if (col_last) begin
        tile_col_r <= tcol_last ? '0 : tile_col_r + TC_W'(1);
      end
      if (line_end) begin
        row_in_tile_r <= rit_last ? '0 : row_in_tile_r + CIT_W'(1);
        if (rit_last) begin
          tile_row_r <= trow_last ? '0 : tile_row_r + TC_W'(1);
        end
      end
    end
  end

  // Out-of-range samples contribute nothing.
  logic [GRAY_W-1:0] sample;

  always_comb begin
    if (in_pixel_value[PIX_W-1] || (in_pixel_value[GRAY_W-1:0] > max_gray_r)) begin
      sample = '0;
    end else begin
      sample = in_pixel_value[GRAY_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Accumulate stage. The memory read is issued with the transfer; the item
  // then sits here while its read data arrives and is written back on the
  // next enabled edge.
  // --------------------------------------------------------------------------
  logic              b_valid_r;
  logic [GRAY_W-1:0] b_sample_r;
  logic [TC_W-1:0]   b_tc_r;
  logic              b_emit_r;
  tile_flags_t       b_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      b_sample_r          <= sample;
      b_tc_r              <= tile_col_r;
      b_emit_r            <= col_last && rit_last;
      b_flags_r.row_end   <= tcol_last;
      b_flags_r.image_end <= tcol_last && trow_last;
    end
  end

  // Tile-sum memory, one entry per tile column, with a valid bit per entry so
  // that a restart drops every sum at once.
  logic [SUM_W-1:0]     sums_mem [ICON_SIDE];
  logic [ICON_SIDE-1:0] entry_valid_r;
  logic [SUM_W-1:0]     rd_data_r;
  logic                 rd_vld_r;
  logic                 wr_en;
  logic [SUM_W-1:0]     wr_data;
  logic [SUM_W-1:0]     old_sum;
  logic [SUM_W-1:0]     new_sum;

  // Last written entry, forwarded when the next item reads the same column
  // in the cycle of the write.
  logic                 fwd_valid_r;
  logic [TC_W-1:0]      fwd_addr_r;
  logic [SUM_W-1:0]     fwd_data_r;
  logic                 fwd_hit;

  assign wr_en   = en && b_valid_r;
  assign fwd_hit = fwd_valid_r && (fwd_addr_r == b_tc_r);

  always_comb begin
    if (fwd_hit) begin
      old_sum = fwd_data_r;
    end else if (rd_vld_r) begin
      old_sum = rd_data_r;
    end else begin
      old_sum = '0;
    end
    new_sum = old_sum + SUM_W'(b_sample_r);
    // The emitted tile leaves its column cleared for the next tile row.
    wr_data = b_emit_r ? '0 : new_sum;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_data_r <= sums_mem[tile_col_r];
    end
    if (wr_en) begin
      sums_mem[b_tc_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      entry_valid_r <= '0;
      rd_vld_r      <= 1'b0;
      fwd_valid_r   <= 1'b0;
    end else if (en) begin
      rd_vld_r    <= entry_valid_r[tile_col_r];
      fwd_valid_r <= b_valid_r;
      if (b_valid_r) begin
        entry_valid_r[b_tc_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fwd_addr_r <= b_tc_r;
      fwd_data_r <= wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // Divide the finished tile sum by the tile area.
  // --------------------------------------------------------------------------
  tile_flags_t div_flags;

  bads_divider #(
    .SUM_W (SUM_W),
    .DIV_W (DIV_W),
    .Q_W   (Q_W),
    .TC_W  (TC_W)
  ) u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (b_valid_r && b_emit_r),
    .in_sum    (new_sum),
    .divisor   (bs_sq_r),
    .in_tc     (b_tc_r),
    .in_flags  (b_flags_r),
    .out_valid (div_out_valid),
    .out_quot  (out_average),
    .out_tc    (out_tile_column),
    .out_flags (div_flags)
  );

  assign out_valid     = div_out_valid;
  assign out_row_end   = div_flags.row_end;
  assign out_image_end = div_flags.image_end;

`ifndef SYNTHESIS
  // The end-of-row flag marks exactly the last icon column.
  a_row_end_column: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_row_end == (out_tile_column == TC_W'(ICON_SIDE - 1))))
    else $error("row_end flag does not match the icon column");

  // The end-of-image flag only comes with the end of a row.
  a_image_end_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_image_end) |-> out_row_end)
    else $error("image_end without row_end");

  // The input side only stalls behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // A tile sum never wraps around.
  a_sum_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (new_sum >= old_sum))
    else $error("tile sum overflowed");

  // An item written back has its forwarded copy on the next enabled edge.
  a_fwd_track: assert property (@(posedge clk) disable iff (!rst_n || restart)
    wr_en |=> (fwd_valid_r && (fwd_addr_r == $past(b_tc_r))))
    else $error("forwarding register lost the last write");
`endif

endmodule

[verif/tb_block_average_downscale_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_block_average_downscale_unit: self-checking bench for the icon downscaler
// Streams grey samples into the unit and keeps a cycle-free model of the tile
// sums next to it. Every icon pixel that the model produces is queued and
// compared field by field with what the unit emits. Directed checks cover the
// sample range and the block size clamping. Random images at several tile
// sizes follow, with bursts of input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_block_average_downscale_unit;
  import bads_pkg::*;

  // Cycles to wait after the last expected icon pixel before touching the
  // configuration. A sample that closes no tile still sits in the unit's
  // register stages after the last icon pixel has left.
  localparam int DRAIN_CYCLES = 32;
  localparam int ICON_W       = $clog2(ICON_SIDE_DEF);

  // One icon pixel as it leaves the unit.
  typedef struct {
    logic [GRAY_W-1:0] average;
    logic [ICON_W-1:0] column;
    logic              row_end;
    logic              image_end;
  } icon_pixel_t;

  logic                    clk             = 1'b0;
  logic                    rst_n           = 1'b0;
  logic                    cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index       = REG_MAX_GRAY;
  logic [CFG_W-1:0]        cfg_wdata       = '0;
  logic                    in_valid        = 1'b0;
  logic                    in_stall;
  logic signed [PIX_W-1:0] in_pixel_value  = '0;
  logic                    out_valid;
  logic                    out_stall       = 1'b0;
  logic [GRAY_W-1:0]       out_average;
  logic [ICON_W-1:0]       out_tile_column;
  logic                    out_row_end;
  logic                    out_image_end;

  block_average_downscale_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_value (in_pixel_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_average    (out_average),
    .out_tile_column(out_tile_column),
    .out_row_end    (out_row_end),
    .out_image_end  (out_image_end)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Downscaler model: register copies, per-column tile sums and the position
  // of the next sample inside the image.
  // --------------------------------------------------------------------------
  logic [GRAY_W-1:0] gray_limit;
  logic [BLK_W-1:0]  block_reg;
  logic [27:0]       tile_sum [ICON_SIDE_DEF];
  logic [11:0]       sample_col;
  logic [5:0]        row_in_tile;
  logic [5:0]        icon_row;

  icon_pixel_t expected_icon[$];
  int          err_count;

  // Random idling controls. The stall driver reads stall_en every cycle.
  bit pix_gap_en;
  bit stall_en;
  bit busy_mode;
  int stall_left;

  // Writing block_size, and reset, start a fresh image.
  function automatic void restart_image();
    foreach (tile_sum[k]) tile_sum[k] = '0;
    sample_col  = '0;
    row_in_tile = '0;
    icon_row    = '0;
  endfunction

  // Adds one accepted sample to its tile sum. When the sample is the
  // bottom-right corner of a tile, the tile average is queued as an expected
  // icon pixel and that column sum starts over.
  function automatic void downscale_sample(input logic signed [PIX_W-1:0] pix);
    int unsigned blk, side, col, nxt;
    logic [GRAY_W-1:0] sample;
    icon_pixel_t px;
    // A block size of zero acts as one; anything past the largest tile clamps.
    if (block_reg == 0) blk = 1;
    else if (block_reg > TILE_MAX_DEF) blk = TILE_MAX_DEF;
    else blk = block_reg;
    side = ICON_SIDE_DEF * blk;
    // Negative samples and samples above the grey limit add nothing.
    if (pix[PIX_W-1] || pix[GRAY_W-1:0] > gray_limit) sample = '0;
    else sample = pix[GRAY_W-1:0];
    col = sample_col / blk;
    tile_sum[col] = tile_sum[col] + sample;
    if (sample_col % blk == blk - 1 && row_in_tile == blk - 1) begin
      px.average   = GRAY_W'(tile_sum[col] / (blk * blk));
      px.column    = ICON_W'(col);
      px.row_end   = (col == ICON_SIDE_DEF - 1);
      px.image_end = px.row_end && (icon_row == ICON_SIDE_DEF - 1);
      expected_icon.push_back(px);
      tile_sum[col] = '0;
    end
    // Counters are stepped in full-width integers so that a 4096-sample row
    // or a 64-row tile does not wrap the narrow copies before the compare.
    nxt = sample_col + 1;
    if (nxt >= side) begin
      sample_col = '0;
      nxt = row_in_tile + 1;
      if (nxt >= blk) begin
        row_in_tile = '0;
        nxt = icon_row + 1;
        icon_row = (nxt >= ICON_SIDE_DEF) ? '0 : 6'(nxt);
      end else begin
        row_in_tile = 6'(nxt);
      end
    end else begin
      sample_col = 12'(nxt);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Shared driving tasks.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    err_count++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Register write; the model follows at the same edge. The trailing edge
  // keeps two writes in a row from driving cfg_we twice in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_GRAY) begin
      gray_limit = val[GRAY_W-1:0];
    end else if (idx == REG_BLOCK_SIZE) begin
      block_reg = val[BLK_W-1:0];
      restart_image();
    end
    @(posedge clk);
  endtask

  // Offers one sample and returns at the edge of its transfer. The sample
  // stays on the port untouched while the unit stalls.
  task automatic send_pixel(input logic signed [PIX_W-1:0] pix);
    if (pix_gap_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_value <= pix;
    do @(posedge clk); while (in_stall !== 1'b0);
    downscale_sample(pix);
  endtask

  // Lowers valid and waits until every queued icon pixel has arrived, then
  // lets the pipeline run empty with the output side open.
  task automatic drain_pipeline();
    bit saved_stall;
    in_valid <= 1'b0;
    while (expected_icon.size() != 0) @(posedge clk);
    saved_stall = stall_en;
    stall_en = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    stall_en = saved_stall;
  endtask

  // Mostly in-range grey levels, with a share of the limit itself, zero,
  // values above the limit and negative samples.
  function automatic logic signed [PIX_W-1:0] random_sample(input logic [GRAY_W-1:0] lim);
    int unsigned pick;
    logic [GRAY_W-1:0] raw;
    pick = $urandom_range(0, 19);
    raw  = GRAY_W'($urandom);
    if (pick < 13) return PIX_W'($urandom_range(0, lim));
    else if (pick < 15) return pick[0] ? {1'b0, lim} : '0;
    else if (pick < 17) return {1'b0, raw};
    else return {1'b1, raw};
  endfunction

  // Random stream; every 64 samples the gap and stall settings are drawn
  // again, so stretches with and without idling alternate.
  task automatic stream_random_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) begin
        pix_gap_en = busy_mode && $urandom_range(0, 2) != 0;
        stall_en   = busy_mode && $urandom_range(0, 2) != 0;
      end
      send_pixel(random_sample(gray_limit));
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checker: each icon pixel transfer is matched to the oldest entry.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    icon_pixel_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_icon.size() == 0) begin
        report_mismatch($sformatf("icon pixel at column %0d with nothing expected",
                                  out_tile_column));
      end else begin
        want = expected_icon.pop_front();
        if (out_average !== want.average)
          report_mismatch($sformatf("average got %0d expected %0d (column %0d)",
                                    out_average, want.average, want.column));
        if (out_tile_column !== want.column)
          report_mismatch($sformatf("tile_column got %0d expected %0d",
                                    out_tile_column, want.column));
        if (out_row_end !== want.row_end)
          report_mismatch($sformatf("row_end got %0b expected %0b (column %0d)",
                                    out_row_end, want.row_end, want.column));
        if (out_image_end !== want.image_end)
          report_mismatch($sformatf("image_end got %0b expected %0b (column %0d)",
                                    out_image_end, want.image_end, want.column));
      end
    end
  end

  // Output stall in bursts of random length while enabled.
  always @(posedge clk) begin
    if (!stall_en || !rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Reset leaves a one-sample tile and a limit of 255, so every sample is an
  // icon pixel of its own. Extremes on both sides of the limit and of zero.
  task automatic test_reset_defaults();
    send_pixel(17'sd0);
    send_pixel(17'sd255);
    send_pixel(17'sd256);
    send_pixel(17'sd65535);
    send_pixel(-17'sd1);
    send_pixel(-17'sd65536);
    send_pixel(17'sd1);
    send_pixel(17'sd254);
    send_pixel(17'sh0AAAA);
    drain_pipeline();
  endtask

  // A new grey limit takes effect at once and keeps the image position.
  task automatic test_gray_limit_edges();
    write_reg(REG_MAX_GRAY, 16'hFFFF);
    send_pixel(17'sd65535);
    send_pixel(17'sd65534);
    send_pixel(-17'sd1);
    drain_pipeline();
    write_reg(REG_MAX_GRAY, 16'd1);
    send_pixel(17'sd1);
    send_pixel(17'sd2);
    drain_pipeline();
  endtask

  // Block size zero behaves as one; sizes past the largest tile clamp to it,
  // so a handful of samples there closes no tile.
  task automatic test_block_size_clamping();
    write_reg(REG_BLOCK_SIZE, 16'd0);
    send_pixel(17'sd1);
    send_pixel(17'sd0);
    send_pixel(17'sd7);
    drain_pipeline();
    write_reg(REG_BLOCK_SIZE, 16'd127);
    repeat (4) send_pixel(random_sample(gray_limit));
    drain_pipeline();
    write_reg(REG_BLOCK_SIZE, 16'd64);
    repeat (2) send_pixel(random_sample(gray_limit));
    drain_pipeline();
  endtask

  // One-sample tiles over several icon rows: row end flags, and a limit
  // change partway through that must not restart the count.
  task automatic test_full_image_wrap();
    busy_mode = 1'b1;
    write_reg(REG_BLOCK_SIZE, 16'd1);
    write_reg(REG_MAX_GRAY, 16'hFFFF);
    stream_random_pixels(128);
    drain_pipeline();
    write_reg(REG_MAX_GRAY, CFG_W'($urandom_range(1, 65535)));
    stream_random_pixels(64);
    drain_pipeline();
  endtask

  // Larger tiles. Each phase ends mid-image, so the next block size write
  // also shows that a restart drops partial sums.
  task automatic test_tile_sizes();
    busy_mode = 1'b1;
    write_reg(REG_BLOCK_SIZE, 16'd2);
    write_reg(REG_MAX_GRAY, CFG_W'($urandom_range(1, 65535)));
    stream_random_pixels(250);
    drain_pipeline();
    write_reg(REG_BLOCK_SIZE, 16'd3);
    write_reg(REG_MAX_GRAY, CFG_W'($urandom_range(200, 4000)));
    stream_random_pixels(420);
    drain_pipeline();
    write_reg(REG_BLOCK_SIZE, 16'd64);
    stream_random_pixels(20);
    drain_pipeline();
  endtask

  // Back-to-back transfers with both sides always ready.
  task automatic test_steady_stream();
    busy_mode  = 1'b0;
    pix_gap_en = 1'b0;
    stall_en   = 1'b0;
    write_reg(REG_BLOCK_SIZE, 16'd2);
    write_reg(REG_MAX_GRAY, 16'd1023);
    stream_random_pixels(200);
    drain_pipeline();
  endtask

  initial begin
    err_count  = 0;
    gray_limit = MAX_GRAY_RST;
    block_reg  = 7'd1;
    restart_image();
    pix_gap_en = 1'b1;
    stall_en   = 1'b1;
    busy_mode  = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_gray_limit_edges();
    test_block_size_clamping();
    test_full_image_wrap();
    test_tile_sizes();
    test_steady_stream();

    if (expected_icon.size() != 0)
      report_mismatch($sformatf("%0d icon pixels never arrived", expected_icon.size()));
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: the slowest legal run stays well under a tenth of this.
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
